// File: hdl/mme_pkg.sv
// shared types and constants of the matrix multiply engine
// transaction structs, request and register codes, arithmetic control
// no dependencies
`default_nettype none

package mme_pkg;

  // request codes of an input transaction
  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_A_ROW_COUNT = 2'd0;
  localparam logic [1:0] CFG_A_COL_COUNT = 2'd1;
  localparam logic [1:0] CFG_B_ROW_COUNT = 2'd2;
  localparam logic [1:0] CFG_B_COL_COUNT = 2'd3;

  // fixed point format of the elements
  localparam int unsigned FRAC_BITS = 16;

  // dimension register width and its reset value
  localparam int unsigned CNT_W     = 4;
  localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         elem_row;
    logic [2:0]         elem_col;
    logic signed [31:0] elem_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         res_row;
    logic [2:0]         res_col;
    logic signed [31:0] res_value;
    logic               dim_error;
    logic               last_flag;
  } res_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic load_prod;
    logic accumulate;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/matrix_multiply_engine.sv
// top level of the matrix multiply engine: element stores, sequencer,
// result register and configuration registers; uses mme_pkg and mme_mac
`default_nettype none

// Usage
// Input transactions arrive on req_i, accepted when start is high and busy
// is low. A load of A or B writes one store element in one cycle and gives
// no result; loads may follow each other in every cycle. A load with a row
// or column at or above MAX_DIM is dropped, request code 3 is dropped.
// A start request computes C = A x B over the dimensions in the count
// registers and puts every C element on res_o in row-major order, each for
// one cycle with res_valid_o high; the final one has last_flag set. When
// A columns differ from B rows, one error result appears the cycle after
// the start and busy never rises.
// For a start request, each term of a sum goes through a store read, the
// shared multiplier and the accumulator in that order, and each element
// then goes through the output state, where the sum is rounded and registered.
// busy is high while the products are computed and is low again when the
// last result shows, so the next transaction may already be accepted then.
// The receiver cannot stall results. The user writes the count registers
// through cfg_valid_i/cfg_ready_o only while idle; the block does not
// enforce this. Reset sets all counts to 8 and clears control; store
// contents are undefined until written.

module matrix_multiply_engine #(
  parameter int unsigned MAX_DIM     = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire mme_pkg::req_t               req_i,
  output logic                             res_valid_o,
  output mme_pkg::res_t                    res_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [mme_pkg::CNT_W-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CW     = mme_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [CW-1:0] a_rows_c, a_cols_c, b_rows_c, b_cols_c;

  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0] i_last_q, i_last_d, j_last_q, j_last_d, k_last_q, k_last_d;

  logic signed [VALUE_WIDTH-1:0] a_mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] b_mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] a_rd_q, b_rd_q;
  logic [ADDR_W-1:0]             wr_addr, a_rd_addr, b_rd_addr;

  logic accept, load_ok, wr_a, wr_b, dims_ok, last_elem;
  mme_pkg::mac_ctrl_t            mac_ctrl;
  logic signed [VALUE_WIDTH-1:0] mac_sat;

  mme_pkg::res_t res_q, res_d;
  logic          res_valid_q, res_valid_d;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= mme_pkg::CNT_RESET;
      a_cols_q <= mme_pkg::CNT_RESET;
      b_rows_q <= mme_pkg::CNT_RESET;
      b_cols_q <= mme_pkg::CNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mme_pkg::CFG_A_ROW_COUNT: a_rows_q <= cfg_data_i;
        mme_pkg::CFG_A_COL_COUNT: a_cols_q <= cfg_data_i;
        mme_pkg::CFG_B_ROW_COUNT: b_rows_q <= cfg_data_i;
        mme_pkg::CFG_B_COL_COUNT: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counts limited to 1..MAX_DIM
  function automatic logic [CW-1:0] clamp_cnt(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (v > CW'(MAX_DIM)) begin
      r = CW'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign a_rows_c = clamp_cnt(a_rows_q);
  assign a_cols_c = clamp_cnt(a_cols_q);
  assign b_rows_c = clamp_cnt(b_rows_q);
  assign b_cols_c = clamp_cnt(b_cols_q);
  assign dims_ok  = (a_cols_c == b_rows_c);

  // store write port
  assign load_ok = (32'(req_i.elem_row) < MAX_DIM) && (32'(req_i.elem_col) < MAX_DIM);
  assign wr_a    = accept && (req_i.req_type == mme_pkg::REQ_LOAD_A) && load_ok;
  assign wr_b    = accept && (req_i.req_type == mme_pkg::REQ_LOAD_B) && load_ok;
  assign wr_addr = ADDR_W'(ADDR_W'(req_i.elem_row) * ADDR_W'(MAX_DIM)
                 + ADDR_W'(req_i.elem_col));

  // store read addresses: A(i,k) and B(k,j)
  assign a_rd_addr = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q));
  assign b_rd_addr = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q));

  // element stores
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_mem[wr_addr] <= req_i.elem_value[VALUE_WIDTH-1:0];
    end
    if (wr_b) begin
      b_mem[wr_addr] <= req_i.elem_value[VALUE_WIDTH-1:0];
    end
    a_rd_q <= a_mem[a_rd_addr];
    b_rd_q <= b_mem[b_rd_addr];
  end

  // shared multiply-accumulate unit
  mme_mac #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIM     (MAX_DIM)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .sat_o  (mac_sat)
  );

  assign last_elem = (i_q == i_last_q) && (j_q == j_last_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    i_last_d    = i_last_q;
    j_last_d    = j_last_q;
    k_last_d    = k_last_q;
    mac_ctrl    = '0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_i.req_type == mme_pkg::REQ_START)) begin
          if (!dims_ok) begin
            // dimension mismatch: single error result
            res_valid_d     = 1'b1;
            res_d           = '0;
            res_d.dim_error = 1'b1;
            res_d.last_flag = 1'b1;
          end else begin
            i_d            = '0;
            j_d            = '0;
            k_d            = '0;
            i_last_d       = IDX_W'(a_rows_c - CW'(1));
            j_last_d       = IDX_W'(b_cols_c - CW'(1));
            k_last_d       = IDX_W'(a_cols_c - CW'(1));
            mac_ctrl.clear = 1'b1;
            state_d        = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        mac_ctrl.load_prod = 1'b1;
        state_d            = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.accumulate = 1'b1;
        if (k_q == k_last_q) begin
          state_d = S_OUT;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = S_READ;
        end
      end
      S_OUT: begin
        res_valid_d     = 1'b1;
        res_d.res_row   = 3'(i_q);
        res_d.res_col   = 3'(j_q);
        res_d.res_value = 32'(mac_sat);
        res_d.dim_error = 1'b0;
        res_d.last_flag = last_elem;
        mac_ctrl.clear  = 1'b1;
        k_d             = '0;
        if (last_elem) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_READ;
          if (j_q == j_last_q) begin
            j_d = '0;
            i_d = i_q + IDX_W'(1);
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      i_last_q    <= '0;
      j_last_q    <= '0;
      k_last_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      i_last_q    <= i_last_d;
      j_last_q    <= j_last_d;
      k_last_q    <= k_last_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // a mismatched start yields an error result next cycle and no busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.req_type == mme_pkg::REQ_START) && !dims_ok
    |=> res_valid_o && res_o.dim_error && res_o.last_flag && !busy)
    else $error("error result missing after mismatched start");

  // the error result carries no product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.dim_error
    |-> (res_o.res_value == '0) && (res_o.res_row == '0) && (res_o.res_col == '0))
    else $error("error result with nonzero payload");

  // element and sum indexes stay within their limits while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (k_q <= k_last_q) && (i_q <= i_last_q) && (j_q <= j_last_q))
    else $error("element or sum index beyond its limit");

  // the last product result ends the busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_flag && !res_o.dim_error |-> !busy)
    else $error("still busy after last result");

  // a matched start enters the computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.req_type == mme_pkg::REQ_START) && dims_ok |=> busy)
    else $error("matched start did not begin");
`endif

endmodule

`default_nettype wire

// File: hdl/mme_mac.sv
// shared multiply-accumulate unit: one product per step, wide sum,
// round to nearest (ties up) and saturate; uses mme_pkg
`default_nettype none

module mme_mac #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIM     = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mme_pkg::mac_ctrl_t            ctrl_i,
  input  wire logic signed [VALUE_WIDTH-1:0] a_i,
  input  wire logic signed [VALUE_WIDTH-1:0] b_i,
  output logic signed [VALUE_WIDTH-1:0]      sat_o
);

  localparam int unsigned PROD_W = 2 * VALUE_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (mme_pkg::FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] MAX_V    = (ACC_W'(1) << (VALUE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] MIN_V    = ~MAX_V;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;

  // product register, one multiply per step
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_prod) begin
      prod_q <= a_i * b_i;
    end
  end

  // accumulator
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.accumulate) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // rounding and saturation of the finished sum
  always_comb begin
    rnd     = acc_q + HALF_LSB;
    shifted = rnd >>> mme_pkg::FRAC_BITS;
    if (shifted > MAX_V) begin
      sat_o = MAX_V[VALUE_WIDTH-1:0];
    end else if (shifted < MIN_V) begin
      sat_o = MIN_V[VALUE_WIDTH-1:0];
    end else begin
      sat_o = shifted[VALUE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench of the matrix multiply engine
// a scoreboard class predicts every product element; tasks drive loads, starts, counts
// depends on mme_pkg and matrix_multiply_engine
`timescale 1ns / 100ps

module tb;

  localparam int DIM         = 8;
  localparam int REPORT_MAX  = 10;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 4;
  localparam int END_WAIT    = 30;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // product prediction and result checking
  class product_scoreboard;
    logic [31:0] a_mem [DIM*DIM];
    logic [31:0] b_mem [DIM*DIM];
    logic [mme_pkg::CNT_W-1:0] dim_reg [4];
    mme_pkg::res_t product_q [$];
    int unsigned mismatches;
    int unsigned elements_checked;
    int unsigned loads_seen;
    int unsigned products_seen;

    function new();
      foreach (a_mem[n]) begin
        a_mem[n] = '0;
        b_mem[n] = '0;
      end
      foreach (dim_reg[n]) dim_reg[n] = mme_pkg::CNT_RESET;
      mismatches = 0;
      elements_checked = 0;
      loads_seen = 0;
      products_seen = 0;
    endfunction

    function void write_count(logic [1:0] idx, logic [mme_pkg::CNT_W-1:0] val);
      dim_reg[idx] = val;
    endfunction

    // zero counts as one, anything above the store size as the store size
    function int used_dim(logic [1:0] idx);
      int v;
      v = dim_reg[idx];
      if (v < 1) return 1;
      if (v > DIM) return DIM;
      return v;
    endfunction

    // exact sum in q32.32, rounded half up to q16.16, then saturated
    function logic signed [31:0] product_element(int i, int j, int depth);
      longint term, hi_sum, lo_sum, total;
      hi_sum = 0;
      lo_sum = 0;
      for (int k = 0; k < depth; k++) begin
        term = longint'($signed(a_mem[i*DIM+k])) * longint'($signed(b_mem[k*DIM+j]));
        hi_sum += term >>> mme_pkg::FRAC_BITS;
        lo_sum += term & ((longint'(1) << mme_pkg::FRAC_BITS) - 1);
      end
      total = hi_sum + ((lo_sum + (longint'(1) << (mme_pkg::FRAC_BITS - 1)))
                        >>> mme_pkg::FRAC_BITS);
      if (total > SAT_HI) total = SAT_HI;
      if (total < SAT_LO) total = SAT_LO;
      return 32'(total);
    endfunction

    function void note_request(mme_pkg::req_t r);
      mme_pkg::res_t e;
      int ar, ac, br, bc;
      case (r.req_type)
        mme_pkg::REQ_LOAD_A: begin
          a_mem[{r.elem_row, r.elem_col}] = r.elem_value;
          loads_seen++;
        end
        mme_pkg::REQ_LOAD_B: begin
          b_mem[{r.elem_row, r.elem_col}] = r.elem_value;
          loads_seen++;
        end
        mme_pkg::REQ_START: begin
          products_seen++;
          ar = used_dim(mme_pkg::CFG_A_ROW_COUNT);
          ac = used_dim(mme_pkg::CFG_A_COL_COUNT);
          br = used_dim(mme_pkg::CFG_B_ROW_COUNT);
          bc = used_dim(mme_pkg::CFG_B_COL_COUNT);
          if (ac != br) begin
            // shape mismatch: a single error element
            e = '0;
            e.dim_error = 1'b1;
            e.last_flag = 1'b1;
            product_q.push_back(e);
          end else begin
            for (int i = 0; i < ar; i++) begin
              for (int j = 0; j < bc; j++) begin
                e = '0;
                e.res_row   = 3'(i);
                e.res_col   = 3'(j);
                e.res_value = product_element(i, j, ac);
                e.last_flag = (i == ar - 1) && (j == bc - 1);
                product_q.push_back(e);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_element(mme_pkg::res_t got);
      mme_pkg::res_t exp;
      if (product_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: row %0d col %0d value %h err %b last %b",
                   got.res_row, got.res_col, got.res_value, got.dim_error, got.last_flag);
        return;
      end
      exp = product_q.pop_front();
      elements_checked++;
      if (exp.res_row !== got.res_row || exp.res_col !== got.res_col ||
          exp.res_value !== got.res_value || exp.dim_error !== got.dim_error ||
          exp.last_flag !== got.last_flag) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"mismatch: expected row %0d col %0d value %h err %b last %b,",
                    " got row %0d col %0d value %h err %b last %b"},
                   exp.res_row, exp.res_col, exp.res_value, exp.dim_error, exp.last_flag,
                   got.res_row, got.res_col, got.res_value, got.dim_error, got.last_flag);
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  mme_pkg::req_t             req_i;
  logic                      res_valid_o;
  mme_pkg::res_t             res_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [1:0]                cfg_index_i;
  logic [mme_pkg::CNT_W-1:0] cfg_data_i;

  product_scoreboard sb = new();
  bit a_done [DIM*DIM];
  bit b_done [DIM*DIM];
  bit idle_on;
  int items_sent;
  int stall_cycles;

  matrix_multiply_engine #(
    .MAX_DIM    (DIM),
    .VALUE_WIDTH(32)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_element(res_o);
  end

  // watchdog on cycles without any transaction
  initial stall_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // element value mix: small sums, extremes, full range
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    endcase
  endfunction

  function automatic mme_pkg::req_t pack_req(logic [1:0] kind, logic [2:0] row,
                                             logic [2:0] col, logic [31:0] value);
    mme_pkg::req_t r;
    r.req_type   = kind;
    r.elem_row   = row;
    r.elem_col   = col;
    r.elem_value = value;
    return r;
  endfunction

  function automatic mme_pkg::req_t rand_load(logic [1:0] kind, int row, int col);
    return pack_req(kind, 3'(row), 3'(col), rand_value());
  endfunction

  function automatic mme_pkg::req_t rand_start();
    return pack_req(mme_pkg::REQ_START, 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), $urandom());
  endfunction

  // count encodings that the block folds onto the same dimension
  function automatic logic [mme_pkg::CNT_W-1:0] enc_count(int d);
    if (d == 1 && $urandom_range(0, 2) == 0) return '0;
    if (d == DIM && $urandom_range(0, 1) == 0)
      return mme_pkg::CNT_W'($urandom_range(DIM + 1, 15));
    return mme_pkg::CNT_W'(d);
  endfunction

  // one input transaction, with an optional idle burst afterwards
  task automatic send_req(input mme_pkg::req_t r);
    int gap;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
    if (r.req_type == mme_pkg::REQ_LOAD_A) a_done[{r.elem_row, r.elem_col}] = 1'b1;
    if (r.req_type == mme_pkg::REQ_LOAD_B) b_done[{r.elem_row, r.elem_col}] = 1'b1;
    if (r.req_type != REQ_UNUSED) items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= pack_req(mme_pkg::REQ_START, 3'($urandom), 3'($urandom), $urandom());
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // count register write, only issued while the block is idle
  task automatic write_count(input logic [1:0] idx, input logic [mme_pkg::CNT_W-1:0] val);
    if (idle_on && $urandom_range(0, 1) == 0) repeat ($urandom_range(1, 5)) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_count(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop requesting and wait for every predicted element
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.product_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // set the shape, load the operands in random order, then multiply
  task automatic run_product(input int ar, input int ac, input int br, input int bc);
    mme_pkg::req_t batch [$];
    mme_pkg::req_t t;
    int pick;
    write_count(mme_pkg::CFG_A_ROW_COUNT, enc_count(ar));
    write_count(mme_pkg::CFG_A_COL_COUNT, enc_count(ac));
    write_count(mme_pkg::CFG_B_ROW_COUNT, enc_count(br));
    write_count(mme_pkg::CFG_B_COL_COUNT, enc_count(bc));
    for (int i = 0; i < ar; i++)
      for (int k = 0; k < ac; k++)
        if (!a_done[i*DIM+k] || $urandom_range(0, 2) == 0)
          batch.push_back(rand_load(mme_pkg::REQ_LOAD_A, i, k));
    for (int k = 0; k < br; k++)
      for (int j = 0; j < bc; j++)
        if (!b_done[k*DIM+j] || $urandom_range(0, 2) == 0)
          batch.push_back(rand_load(mme_pkg::REQ_LOAD_B, k, j));
    // stray loads anywhere and dropped request codes
    repeat ($urandom_range(0, 3))
      batch.push_back(rand_load($urandom_range(0, 1) ? mme_pkg::REQ_LOAD_A
                                                     : mme_pkg::REQ_LOAD_B,
                                $urandom_range(0, 7), $urandom_range(0, 7)));
    if ($urandom_range(0, 2) == 0) begin
      t = rand_start();
      t.req_type = REQ_UNUSED;
      batch.push_back(t);
    end
    for (int n = batch.size() - 1; n > 0; n--) begin
      pick = $urandom_range(0, n);
      t = batch[n];
      batch[n] = batch[pick];
      batch[pick] = t;
    end
    foreach (batch[n]) send_req(batch[n]);
    send_req(rand_start());
    if ($urandom_range(0, 3) == 0) send_req(rand_start());
    settle();
  endtask

  // stimulus
  initial begin
    int ar, ac, br, bc;
    bit big;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    idle_on     = 1'b1;
    items_sent  = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: 1x1 products at the value extremes, zero counts read as one
    write_count(mme_pkg::CFG_A_ROW_COUNT, '0);
    write_count(mme_pkg::CFG_A_COL_COUNT, mme_pkg::CNT_W'(1));
    write_count(mme_pkg::CFG_B_ROW_COUNT, '0);
    write_count(mme_pkg::CFG_B_COL_COUNT, mme_pkg::CNT_W'(1));
    send_req(pack_req(mme_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
    send_req(pack_req(mme_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
    send_req(pack_req(mme_pkg::REQ_START, 3'd7, 3'd7, 32'hFFFF_FFFF));
    send_req(pack_req(mme_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'h8000_0000));
    send_req(pack_req(mme_pkg::REQ_START, 3'd0, 3'd0, 32'h0));
    send_req(pack_req(mme_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'h8000_0000));
    send_req(pack_req(mme_pkg::REQ_START, 3'd5, 3'd2, 32'h8000_0000));
    // rounding ties, positive and negative
    send_req(pack_req(mme_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'h0000_0001));
    send_req(pack_req(mme_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'h0000_8000));
    send_req(pack_req(mme_pkg::REQ_START, 3'd0, 3'd0, 32'h0));
    send_req(pack_req(mme_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF));
    send_req(pack_req(mme_pkg::REQ_START, 3'd0, 3'd0, 32'h0));
    // dropped request code, corner store addresses
    send_req(pack_req(REQ_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF));
    send_req(pack_req(REQ_UNUSED, 3'd2, 3'd5, 32'hA5A5_5A5A));
    send_req(pack_req(mme_pkg::REQ_LOAD_A, 3'd7, 3'd7, 32'h1234_5678));
    send_req(pack_req(mme_pkg::REQ_LOAD_B, 3'd7, 3'd7, 32'hFEDC_BA98));
    settle();
    // shape mismatch
    write_count(mme_pkg::CFG_A_COL_COUNT, mme_pkg::CNT_W'(2));
    send_req(pack_req(mme_pkg::REQ_START, 3'd3, 3'd4, 32'h5555_AAAA));
    settle();

    // random shapes, mostly small, a few large up to full size, some mismatched
    while (items_sent < 50) begin
      big = ($urandom_range(0, 9) == 0);
      ar = big ? $urandom_range(1, DIM) : $urandom_range(1, 3);
      ac = big ? $urandom_range(1, DIM) : $urandom_range(1, 3);
      bc = big ? $urandom_range(1, DIM) : $urandom_range(1, 3);
      br = ac;
      if ($urandom_range(0, 7) == 0) br = (ac % DIM) + 1;
      run_product(ar, ac, br, bc);
    end

    // closing part back to back, ending on the full size
    idle_on = 1'b0;
    run_product(2, 3, 3, 2);
    run_product(DIM, DIM, DIM, DIM);
    repeat (END_WAIT) @(posedge clk_i);

    $display("ran %0d loads and %0d multiply requests, %0d result elements compared",
             sb.loads_seen, sb.products_seen, sb.elements_checked);
    $display({"shapes from 1x1 to 8x8x8, value extremes, saturation, rounding ties,",
              " mismatches; %0d errors"}, sb.mismatches);
    if (sb.mismatches == 0 && sb.product_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
